/* hdl/lrce_pkg.sv */
// Shared types, codes and constants for the lamp remote command encoder.
package lrce_pkg;

    localparam logic [7:0] HDR_PLAIN    = 8'hB8;
    localparam logic [3:0] HDR_DISCO_HI = 4'hB;
    localparam logic [7:0] COLOR_BASE   = 8'hC8;
    localparam logic [7:0] BRIGHT_BASE  = 8'h90;
    localparam logic [7:0] BRIGHT_MASK  = 8'hF8;
    localparam logic [7:0] RESEND_NUM   = 8'h09;
    localparam logic [3:0] NO_DISCO     = 4'hF;
    localparam logic [3:0] DISCO_LAST   = 4'd8;
    localparam logic [15:0] REMOTE_ID_RST = 16'h0044;

    // command codes
    localparam logic [7:0] CMD_COLOR     = 8'h40;
    localparam logic [7:0] CMD_ALL_OFF   = 8'h41;
    localparam logic [7:0] CMD_ALL_ON    = 8'h42;
    localparam logic [7:0] CMD_SPEED_DN  = 8'h43;
    localparam logic [7:0] CMD_SPEED_UP  = 8'h44;
    localparam logic [7:0] CMD_Z1_ON     = 8'h45;
    localparam logic [7:0] CMD_Z1_OFF    = 8'h46;
    localparam logic [7:0] CMD_Z2_ON     = 8'h47;
    localparam logic [7:0] CMD_Z2_OFF    = 8'h48;
    localparam logic [7:0] CMD_Z3_ON     = 8'h49;
    localparam logic [7:0] CMD_Z3_OFF    = 8'h4A;
    localparam logic [7:0] CMD_Z4_ON     = 8'h4B;
    localparam logic [7:0] CMD_Z4_OFF    = 8'h4C;
    localparam logic [7:0] CMD_DISCO     = 8'h4D;
    localparam logic [7:0] CMD_BRIGHT    = 8'h4E;
    localparam logic [7:0] CMD_WHITE_ALL = 8'hC2;
    localparam logic [7:0] CMD_WHITE_Z1  = 8'hC5;
    localparam logic [7:0] CMD_WHITE_Z2  = 8'hC7;
    localparam logic [7:0] CMD_WHITE_Z3  = 8'hC9;
    localparam logic [7:0] CMD_WHITE_Z4  = 8'hCB;
    localparam logic [7:0] CMD_NIGHT_ALL = 8'hC1;
    localparam logic [7:0] CMD_NIGHT_Z1  = 8'hC6;
    localparam logic [7:0] CMD_NIGHT_Z2  = 8'hC8;
    localparam logic [7:0] CMD_NIGHT_Z3  = 8'hCA;
    localparam logic [7:0] CMD_NIGHT_Z4  = 8'hCC;

    // key codes
    localparam logic [7:0] KEY_ALL_ON    = 8'h01;
    localparam logic [7:0] KEY_ALL_OFF   = 8'h02;
    localparam logic [7:0] KEY_Z1_ON     = 8'h03;
    localparam logic [7:0] KEY_Z1_OFF    = 8'h04;
    localparam logic [7:0] KEY_Z2_ON     = 8'h05;
    localparam logic [7:0] KEY_Z2_OFF    = 8'h06;
    localparam logic [7:0] KEY_Z3_ON     = 8'h07;
    localparam logic [7:0] KEY_Z3_OFF    = 8'h08;
    localparam logic [7:0] KEY_Z4_ON     = 8'h09;
    localparam logic [7:0] KEY_Z4_OFF    = 8'h0A;
    localparam logic [7:0] KEY_SPEED_UP  = 8'h0B;
    localparam logic [7:0] KEY_SPEED_DN  = 8'h0C;
    localparam logic [7:0] KEY_DISCO     = 8'h0D;
    localparam logic [7:0] KEY_BRIGHT    = 8'h0E;
    localparam logic [7:0] KEY_COLOR     = 8'h0F;
    localparam logic [7:0] KEY_WHITE_ALL = 8'h11;
    localparam logic [7:0] KEY_NIGHT_ALL = 8'h12;
    localparam logic [7:0] KEY_WHITE_Z1  = 8'h13;
    localparam logic [7:0] KEY_NIGHT_Z1  = 8'h14;
    localparam logic [7:0] KEY_WHITE_Z2  = 8'h15;
    localparam logic [7:0] KEY_NIGHT_Z2  = 8'h16;
    localparam logic [7:0] KEY_WHITE_Z3  = 8'h17;
    localparam logic [7:0] KEY_NIGHT_Z3  = 8'h18;
    localparam logic [7:0] KEY_WHITE_Z4  = 8'h19;
    localparam logic [7:0] KEY_NIGHT_Z4  = 8'h1A;

    // outcome codes
    localparam logic [1:0] OUT_SENT    = 2'd0;
    localparam logic [1:0] OUT_UNKNOWN = 2'd1;
    localparam logic [1:0] OUT_BAD_LEN = 2'd2;

    localparam logic [5:0] LEN_SHORT = 6'd2;
    localparam logic [5:0] LEN_LONG  = 6'd3;

    typedef struct packed {
        logic [7:0] command_code;
        logic [7:0] argument_byte;
        logic [5:0] message_length;
    } request_t;

    typedef struct packed {
        logic [7:0] color_level;
        logic [7:0] bright_zone;
        logic [7:0] packet_sequence;
        logic [3:0] disco_index;
        logic [7:0] fallback_sequence;
    } lamp_state_t;

    typedef struct packed {
        logic [1:0] outcome;
        logic [7:0] resend_count;
        logic [7:0] sequence_out;
        logic [7:0] key_out;
        logic [7:0] bright_out;
        logic [7:0] color_out;
        logic [7:0] remote_low;
        logic [7:0] remote_high;
        logic [7:0] header_byte;
    } packet_t;

endpackage

/* hdl/lamp_remote_command_encoder.sv */
// Top level of the lamp remote command encoder: request register, state and packet register.
// A request waits in the request register, then its decoded packet in the packet register.
// Throughput: one request per cycle while the sink is ready; the request register advances
// whenever the packet register is empty or being taken, so neither side sees bubbles.
// Reset (rst_n low, asynchronous): both stages empty, remote_id 0x0044, colour and
// brightness 0, sequence and fallback counter 1, disco mode off (index 15).
module lamp_remote_command_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: remote_id
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] command_code, [15:8] argument_byte, [21:16] message_length, [23:22] zero
    input  logic [23:0] s_axis_tdata,
    // packet side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] header_byte, [15:8] remote_high, [23:16] remote_low, [31:24] color_out,
    // [39:32] bright_out, [47:40] key_out, [55:48] sequence_out, [63:56] resend_count
    output logic [63:0] m_axis_tdata,
    // [1:0] outcome
    output logic [1:0]  m_axis_tuser
);
    import lrce_pkg::*;

    logic        req_valid_reg;
    request_t    req_reg;
    logic        out_valid_reg;
    packet_t     pkt_reg;
    logic [15:0] remote_id_reg;
    lamp_state_t state_reg;
    packet_t     pkt_next;
    lamp_state_t state_next;
    logic        advance;

    // move the held request into the packet register when that slot frees up
    assign advance       = req_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !req_valid_reg || advance;

    lrce_decode u_decode
    (
        .req       (req_reg),
        .cur       (state_reg),
        .remote_id (remote_id_reg),
        .pkt       (pkt_next),
        .nxt       (state_next)
    );

    // remote identity; user must write it only while no request is in flight, unchecked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remote_id_reg <= REMOTE_ID_RST;
        end
        else if (cfg_wr_en)
        begin
            remote_id_reg <= cfg_wr_data;
        end
    end

    // request stage: take a new request whenever the stage is empty or advancing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            req_valid_reg <= s_axis_tvalid;
        end
    end

    // unpack the bus fields, command code in the lowest byte
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            req_reg <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[21:16]};
        end
    end

    // lamp state: commit exactly once per request, as it moves to the packet register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.color_level       <= 8'd0;
            state_reg.bright_zone       <= 8'd0;
            state_reg.packet_sequence   <= 8'd1;
            state_reg.disco_index       <= NO_DISCO;
            state_reg.fallback_sequence <= 8'd1;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // packet stage: hold until taken, refill when the request stage advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pkt_reg <= pkt_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pkt_reg[63:0];
    assign m_axis_tuser  = pkt_reg.outcome;

endmodule

/* hdl/lrce_decode.sv */
// Command decode: one request and the current lamp state give the packet and the next state.
module lrce_decode
(
    input  lrce_pkg::request_t    req,
    input  lrce_pkg::lamp_state_t cur,
    input  logic [15:0]           remote_id,
    output lrce_pkg::packet_t     pkt,
    output lrce_pkg::lamp_state_t nxt
);
    import lrce_pkg::*;

    logic [7:0]  key;
    logic [7:0]  header;
    logic [7:0]  plain_hdr;
    logic        known;
    logic        leave_disco;
    logic        len_ok;
    logic [7:0]  seq;
    logic [3:0]  disco_step;
    lamp_state_t upd;

    always_comb
    begin
        plain_hdr = ((cur.disco_index != 4'd0) && (cur.disco_index <= DISCO_LAST))
                    ? {HDR_DISCO_HI, cur.disco_index} : HDR_PLAIN;
        if (cur.disco_index == DISCO_LAST || cur.disco_index > DISCO_LAST)
        begin
            disco_step = 4'd0;
        end
        else
        begin
            disco_step = cur.disco_index + 4'd1;
        end

        upd         = cur;
        key         = 8'h00;
        header      = plain_hdr;
        known       = 1'b1;
        leave_disco = 1'b0;

        unique case (req.command_code)
            CMD_COLOR:
            begin
                leave_disco     = 1'b1;
                key             = KEY_COLOR;
                upd.color_level = COLOR_BASE - req.argument_byte;
                header          = {HDR_DISCO_HI, 4'd0};
            end
            CMD_ALL_OFF:  key = KEY_ALL_OFF;
            CMD_ALL_ON:
            begin
                key                  = KEY_ALL_ON;
                upd.bright_zone[2:0] = 3'd0;
            end
            CMD_SPEED_DN: key = KEY_SPEED_DN;
            CMD_SPEED_UP: key = KEY_SPEED_UP;
            CMD_Z1_ON:
            begin
                key                  = KEY_Z1_ON;
                upd.bright_zone[2:0] = 3'd1;
            end
            CMD_Z1_OFF:   key = KEY_Z1_OFF;
            CMD_Z2_ON:
            begin
                key                  = KEY_Z2_ON;
                upd.bright_zone[2:0] = 3'd2;
            end
            CMD_Z2_OFF:   key = KEY_Z2_OFF;
            CMD_Z3_ON:
            begin
                key                  = KEY_Z3_ON;
                upd.bright_zone[2:0] = 3'd3;
            end
            CMD_Z3_OFF:   key = KEY_Z3_OFF;
            CMD_Z4_ON:
            begin
                key                  = KEY_Z4_ON;
                upd.bright_zone[2:0] = 3'd4;
            end
            CMD_Z4_OFF:   key = KEY_Z4_OFF;
            CMD_DISCO:
            begin
                key             = KEY_DISCO;
                upd.disco_index = disco_step;
                header          = {HDR_DISCO_HI, disco_step};
            end
            CMD_BRIGHT:
            begin
                key                  = KEY_BRIGHT;
                upd.bright_zone[7:3] = BRIGHT_BASE[7:3] - req.argument_byte[4:0];
            end
            CMD_WHITE_ALL: begin leave_disco = 1'b1; key = KEY_WHITE_ALL; end
            CMD_WHITE_Z1:  begin leave_disco = 1'b1; key = KEY_WHITE_Z1;  end
            CMD_WHITE_Z2:  begin leave_disco = 1'b1; key = KEY_WHITE_Z2;  end
            CMD_WHITE_Z3:  begin leave_disco = 1'b1; key = KEY_WHITE_Z3;  end
            CMD_WHITE_Z4:  begin leave_disco = 1'b1; key = KEY_WHITE_Z4;  end
            CMD_NIGHT_ALL: begin leave_disco = 1'b1; key = KEY_NIGHT_ALL; end
            CMD_NIGHT_Z1:  begin leave_disco = 1'b1; key = KEY_NIGHT_Z1;  end
            CMD_NIGHT_Z2:  begin leave_disco = 1'b1; key = KEY_NIGHT_Z2;  end
            CMD_NIGHT_Z3:  begin leave_disco = 1'b1; key = KEY_NIGHT_Z3;  end
            CMD_NIGHT_Z4:  begin leave_disco = 1'b1; key = KEY_NIGHT_Z4;  end
            default:       known = 1'b0;
        endcase

        // white, night and colour leave disco mode; white and night take the plain header, colour keeps its own
        if (leave_disco)
        begin
            upd.disco_index = NO_DISCO;
            if (req.command_code != CMD_COLOR)
            begin
                header = HDR_PLAIN;
            end
        end

        // a zero sequence byte borrows the fallback counter
        if (cur.packet_sequence == 8'd0)
        begin
            seq                   = cur.fallback_sequence;
            upd.fallback_sequence = cur.fallback_sequence + 8'd1;
        end
        else
        begin
            seq = cur.packet_sequence;
        end
        upd.packet_sequence = seq + 8'd1;

        len_ok = (req.message_length == LEN_SHORT) || (req.message_length == LEN_LONG);

        pkt = '0;
        nxt = cur;
        if (!len_ok)
        begin
            pkt.outcome = OUT_BAD_LEN;
        end
        else if (!known)
        begin
            pkt.outcome = OUT_UNKNOWN;
        end
        else
        begin
            nxt              = upd;
            pkt.outcome      = OUT_SENT;
            pkt.header_byte  = header;
            pkt.remote_high  = remote_id[15:8];
            pkt.remote_low   = remote_id[7:0];
            pkt.color_out    = upd.color_level;
            pkt.bright_out   = upd.bright_zone;
            pkt.key_out      = key;
            pkt.sequence_out = seq;
            pkt.resend_count = RESEND_NUM;
        end
    end

endmodule

/* verif/testbench.sv */
// Self-checking stream testbench for the lamp remote command encoder.
`timescale 1ns / 100ps

module testbench;

    import lrce_pkg::*;

    // One directed row: the request, whether its packet is typed in here, and that packet.
    // Rows without a typed packet are checked against the encoder prediction instead.
    typedef struct packed {
        request_t req;
        logic     fixed;
        packet_t  want;
    } directed_row_t;

    localparam int unsigned RANDOM_PHASES    = 8;
    localparam int unsigned ITEMS_PER_PHASE  = 200;
    localparam int unsigned SINK_HOLD_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES     = 8;
    // Longest correct quiet stretch is a long sender gap plus a long sink stall plus the
    // long sink hold; the limit is many times over that.
    localparam int unsigned WATCHDOG_LIMIT   = 2000;

    localparam packet_t BAD_LEN_PKT = {OUT_BAD_LEN, 64'h0};
    localparam packet_t UNKNOWN_PKT = {OUT_UNKNOWN, 64'h0};
    localparam packet_t NOT_TYPED   = '0;

    localparam logic [7:0] LAMP_CMDS [0:24] = '{
        CMD_COLOR, CMD_ALL_OFF, CMD_ALL_ON, CMD_SPEED_DN, CMD_SPEED_UP,
        CMD_Z1_ON, CMD_Z1_OFF, CMD_Z2_ON, CMD_Z2_OFF, CMD_Z3_ON,
        CMD_Z3_OFF, CMD_Z4_ON, CMD_Z4_OFF, CMD_DISCO, CMD_BRIGHT,
        CMD_WHITE_ALL, CMD_WHITE_Z1, CMD_WHITE_Z2, CMD_WHITE_Z3, CMD_WHITE_Z4,
        CMD_NIGHT_ALL, CMD_NIGHT_Z1, CMD_NIGHT_Z2, CMD_NIGHT_Z3, CMD_NIGHT_Z4
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Mirror of the encoder state and its remote identity register
    lamp_state_t lamp;
    logic [15:0] remote_id_mirror;

    packet_t     pending_packets [$];
    int unsigned fail_count = 0;

    // Knobs shared between the request sender and the packet sink
    bit sender_gaps_on = 1'b1;
    bit sink_stalls_on = 1'b1;
    bit sink_hold_req  = 1'b0;

    always #1 clk = ~clk;

    lamp_remote_command_encoder u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Work out the packet one accepted request produces, and advance the mirrored state.
    task automatic predict_packet(input request_t req, output packet_t pkt);
        logic [7:0] plain_hdr;
        logic [7:0] seq;
        logic       to_white;
        pkt      = '0;
        to_white = 1'b0;
        // Bad length: status only, state untouched
        if (req.message_length != LEN_SHORT && req.message_length != LEN_LONG)
        begin
            pkt.outcome = OUT_BAD_LEN;
            return;
        end
        // Disco indexes outside 1..8 count as no disco mode
        plain_hdr = (lamp.disco_index >= 4'd1 && lamp.disco_index <= DISCO_LAST) ?
                    {HDR_DISCO_HI, lamp.disco_index} : HDR_PLAIN;
        pkt.header_byte = plain_hdr;
        case (req.command_code)
            CMD_COLOR:
            begin
                lamp.color_level = COLOR_BASE - req.argument_byte;
                lamp.disco_index = NO_DISCO;
                pkt.header_byte  = {HDR_DISCO_HI, 4'h0};
                pkt.key_out      = KEY_COLOR;
            end
            CMD_ALL_OFF:  pkt.key_out = KEY_ALL_OFF;
            CMD_ALL_ON:
            begin
                lamp.bright_zone[2:0] = 3'd0;
                pkt.key_out = KEY_ALL_ON;
            end
            CMD_SPEED_DN: pkt.key_out = KEY_SPEED_DN;
            CMD_SPEED_UP: pkt.key_out = KEY_SPEED_UP;
            CMD_Z1_ON:
            begin
                lamp.bright_zone[2:0] = 3'd1;
                pkt.key_out = KEY_Z1_ON;
            end
            CMD_Z1_OFF:   pkt.key_out = KEY_Z1_OFF;
            CMD_Z2_ON:
            begin
                lamp.bright_zone[2:0] = 3'd2;
                pkt.key_out = KEY_Z2_ON;
            end
            CMD_Z2_OFF:   pkt.key_out = KEY_Z2_OFF;
            CMD_Z3_ON:
            begin
                lamp.bright_zone[2:0] = 3'd3;
                pkt.key_out = KEY_Z3_ON;
            end
            CMD_Z3_OFF:   pkt.key_out = KEY_Z3_OFF;
            CMD_Z4_ON:
            begin
                lamp.bright_zone[2:0] = 3'd4;
                pkt.key_out = KEY_Z4_ON;
            end
            CMD_Z4_OFF:   pkt.key_out = KEY_Z4_OFF;
            CMD_DISCO:
            begin
                // step modulo 9; from no disco mode start at 0
                lamp.disco_index = (lamp.disco_index < DISCO_LAST) ?
                                   lamp.disco_index + 4'd1 : 4'd0;
                pkt.header_byte  = {HDR_DISCO_HI, lamp.disco_index};
                pkt.key_out      = KEY_DISCO;
            end
            CMD_BRIGHT:
            begin
                lamp.bright_zone = ((BRIGHT_BASE - {req.argument_byte[4:0], 3'b000})
                                    & BRIGHT_MASK) | (lamp.bright_zone & ~BRIGHT_MASK);
                pkt.key_out = KEY_BRIGHT;
            end
            CMD_WHITE_ALL: begin pkt.key_out = KEY_WHITE_ALL; to_white = 1'b1; end
            CMD_WHITE_Z1:  begin pkt.key_out = KEY_WHITE_Z1;  to_white = 1'b1; end
            CMD_WHITE_Z2:  begin pkt.key_out = KEY_WHITE_Z2;  to_white = 1'b1; end
            CMD_WHITE_Z3:  begin pkt.key_out = KEY_WHITE_Z3;  to_white = 1'b1; end
            CMD_WHITE_Z4:  begin pkt.key_out = KEY_WHITE_Z4;  to_white = 1'b1; end
            CMD_NIGHT_ALL: begin pkt.key_out = KEY_NIGHT_ALL; to_white = 1'b1; end
            CMD_NIGHT_Z1:  begin pkt.key_out = KEY_NIGHT_Z1;  to_white = 1'b1; end
            CMD_NIGHT_Z2:  begin pkt.key_out = KEY_NIGHT_Z2;  to_white = 1'b1; end
            CMD_NIGHT_Z3:  begin pkt.key_out = KEY_NIGHT_Z3;  to_white = 1'b1; end
            CMD_NIGHT_Z4:  begin pkt.key_out = KEY_NIGHT_Z4;  to_white = 1'b1; end
            default:
            begin
                pkt         = '0;
                pkt.outcome = OUT_UNKNOWN;
                return;
            end
        endcase
        // White and night drop disco mode and always send the plain header
        if (to_white)
        begin
            lamp.disco_index = NO_DISCO;
            pkt.header_byte  = HDR_PLAIN;
        end
        // A zero sequence byte borrows the fallback counter
        if (lamp.packet_sequence == 8'd0)
        begin
            seq = lamp.fallback_sequence;
            lamp.fallback_sequence = lamp.fallback_sequence + 8'd1;
        end
        else
            seq = lamp.packet_sequence;
        lamp.packet_sequence = seq + 8'd1;

        pkt.remote_high  = remote_id_mirror[15:8];
        pkt.remote_low   = remote_id_mirror[7:0];
        pkt.color_out    = lamp.color_level;
        pkt.bright_out   = lamp.bright_zone;
        pkt.sequence_out = seq;
        pkt.resend_count = RESEND_NUM;
        pkt.outcome      = OUT_SENT;
    endtask

    // Packet sent under the reset remote identity, for typed directed rows
    function automatic packet_t sent_packet(input logic [7:0] hdr, input logic [7:0] color,
                                            input logic [7:0] bright, input logic [7:0] key,
                                            input logic [7:0] seq);
        return {OUT_SENT, RESEND_NUM, seq, key, bright, color,
                REMOTE_ID_RST[7:0], REMOTE_ID_RST[15:8], hdr};
    endfunction

    // Mostly well-formed commands with random arguments, the rest noise
    function automatic request_t random_request();
        request_t    req;
        int unsigned roll;
        roll               = $urandom_range(0, 99);
        req.argument_byte  = 8'($urandom_range(0, 255));
        req.message_length = $urandom_range(0, 1) ? LEN_LONG : LEN_SHORT;
        if (roll < 8)
        begin
            // any length, almost always a bad one
            req.command_code   = LAMP_CMDS[5'($urandom_range(0, 24))];
            req.message_length = 6'($urandom_range(0, 63));
        end
        else if (roll < 16)
            req.command_code = 8'($urandom_range(0, 255));
        else if (roll < 28)
            req.command_code = CMD_DISCO;    // extra disco steps to wrap the index
        else
            req.command_code = LAMP_CMDS[5'($urandom_range(0, 24))];
        return req;
    endfunction

    // Offer one request, hold it until taken, then queue its packet and maybe idle.
    task automatic issue_request(input request_t req, input logic fixed, input packet_t want);
        packet_t     pkt;
        int unsigned roll;
        int unsigned gap;
        s_axis_tdata  <= {2'b00, req.message_length, req.argument_byte, req.command_code};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_packet(req, pkt);
        pending_packets.push_back(fixed ? want : pkt);

        gap = 0;
        if (sender_gaps_on)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 95)
                gap = $urandom_range(10, 40);
            else if (roll >= 75)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0)
        begin
            // drop valid and scramble the data while idle
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 24'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every queued packet has come out.
    task automatic drain_packets();
        s_axis_tvalid <= 1'b0;
        while (pending_packets.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Write remote_id while the encoder is idle and track it in the mirror.
    task automatic write_remote_id(input logic [15:0] id);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id;
        @(posedge clk);
        cfg_wr_en        <= 1'b0;
        remote_id_mirror  = id;
    endtask

    // Compare one packet field, logging a mismatch.
    function automatic void check_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected %h, got %h", name, exp_val, got_val);
            fail_count++;
        end
    endfunction

    // Sample packets at the edge they are taken and check them against the oldest entry.
    always @(posedge clk)
    begin
        packet_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_packets.size() == 0)
            begin
                $error("packet with nothing pending: data %h, outcome %h",
                       m_axis_tdata, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_packets.pop_front();
                check_field("header_byte",  want.header_byte,  m_axis_tdata[7:0]);
                check_field("remote_high",  want.remote_high,  m_axis_tdata[15:8]);
                check_field("remote_low",   want.remote_low,   m_axis_tdata[23:16]);
                check_field("color_out",    want.color_out,    m_axis_tdata[31:24]);
                check_field("bright_out",   want.bright_out,   m_axis_tdata[39:32]);
                check_field("key_out",      want.key_out,      m_axis_tdata[47:40]);
                check_field("sequence_out", want.sequence_out, m_axis_tdata[55:48]);
                check_field("resend_count", want.resend_count, m_axis_tdata[63:56]);
                check_field("outcome",      {6'd0, want.outcome}, {6'd0, m_axis_tuser});
            end
        end
    end

    // Packet sink: random ready, a few long stalls, and one long hold on request.
    initial
    begin
        logic        ready_level;
        int unsigned span;
        int unsigned roll;
        m_axis_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            ready_level = 1'b1;
            span        = 1;
            if (sink_hold_req)
            begin
                // hold off long enough for the encoder to fill and stall its input
                ready_level   = 1'b0;
                span          = SINK_HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            else if (sink_stalls_on)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    span = $urandom_range(1, 8);
                else if (roll < 95)
                begin
                    ready_level = 1'b0;
                    span        = $urandom_range(1, 3);
                end
                else
                begin
                    ready_level = 1'b0;
                    span        = $urandom_range(10, 30);
                end
            end
            m_axis_tready <= ready_level;
            repeat (span) @(posedge clk);
        end
    end

    // Watchdog: end the run once nothing moves on either side for too long.
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Request sender: reset, directed table, then random phases under new remote ids.
    initial
    begin
        directed_row_t directed_rows [$];
        logic [15:0]   phase_id;
        int unsigned   phase;
        int unsigned   n;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        lamp.color_level       = 8'd0;
        lamp.bright_zone       = 8'd0;
        lamp.packet_sequence   = 8'd1;
        lamp.disco_index       = NO_DISCO;
        lamp.fallback_sequence = 8'd1;
        remote_id_mirror       = REMOTE_ID_RST;

        // Row layout: command, argument, length, typed flag, typed packet
        // bad lengths at both extremes and unknown codes at both extremes
        directed_rows.push_back({CMD_COLOR,  8'h00, 6'd0,  1'b1, BAD_LEN_PKT});
        directed_rows.push_back({CMD_ALL_ON, 8'hFF, 6'd63, 1'b1, BAD_LEN_PKT});
        directed_rows.push_back({8'h00,      8'h00, LEN_SHORT, 1'b1, UNKNOWN_PKT});
        directed_rows.push_back({8'hFF,      8'hFF, LEN_LONG,  1'b1, UNKNOWN_PKT});
        // first packets after reset: state untouched by the rejected requests
        directed_rows.push_back({CMD_ALL_ON, 8'h00, LEN_SHORT, 1'b1,
                                 sent_packet(HDR_PLAIN, 8'h00, 8'h00, KEY_ALL_ON, 8'd1)});
        directed_rows.push_back({CMD_COLOR,  8'h00, LEN_LONG,  1'b1,
                                 sent_packet(8'hB0, 8'hC8, 8'h00, KEY_COLOR, 8'd2)});
        directed_rows.push_back({CMD_COLOR,  8'hFF, LEN_SHORT, 1'b1,
                                 sent_packet(8'hB0, 8'hC9, 8'h00, KEY_COLOR, 8'd3)});
        directed_rows.push_back({CMD_BRIGHT, 8'h00, LEN_SHORT, 1'b1,
                                 sent_packet(HDR_PLAIN, 8'hC9, 8'h90, KEY_BRIGHT, 8'd4)});
        directed_rows.push_back({CMD_BRIGHT,   8'hFF, LEN_LONG,  1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_ALL_OFF,  8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_SPEED_DN, 8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        // enter disco mode, then zone commands carry the disco header
        directed_rows.push_back({CMD_DISCO,    8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_DISCO,    8'hFF, LEN_LONG,  1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_SPEED_UP, 8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_Z1_ON,    8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_Z1_OFF,   8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_Z2_ON,    8'h00, LEN_LONG,  1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_Z2_OFF,   8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_Z3_ON,    8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_Z3_OFF,   8'h00, LEN_LONG,  1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_Z4_ON,    8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_Z4_OFF,   8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        // white and night leave disco mode
        directed_rows.push_back({CMD_WHITE_ALL, 8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_WHITE_Z1,  8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_WHITE_Z2,  8'h00, LEN_LONG,  1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_WHITE_Z3,  8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_WHITE_Z4,  8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_NIGHT_ALL, 8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_NIGHT_Z1,  8'h00, LEN_LONG,  1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_NIGHT_Z2,  8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_NIGHT_Z3,  8'h00, LEN_SHORT, 1'b0, NOT_TYPED});
        directed_rows.push_back({CMD_NIGHT_Z4,  8'h00, LEN_SHORT, 1'b0, NOT_TYPED});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part runs under the reset remote identity
        foreach (directed_rows[i])
            issue_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].want);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // Pause until the encoder is empty, then move to a new remote identity
            drain_packets();
            case (phase)
                0:       phase_id = 16'hFFFF;
                1:       phase_id = 16'h0000;
                default: phase_id = 16'($urandom_range(0, 65535));
            endcase
            write_remote_id(phase_id);

            // Every third phase streams with no idling on either side
            sender_gaps_on = (phase % 3) != 2;
            sink_stalls_on = (phase % 3) != 2;
            if (phase == 1)
            begin
                // keep offering back to back while the sink holds off
                sender_gaps_on = 1'b0;
                sink_hold_req  = 1'b1;
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++)
                issue_request(random_request(), 1'b0, NOT_TYPED);
        end

        drain_packets();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
